// ===== rtl/assert_macros.svh =====
// assertion macros used by the squelch top level
// no dependencies; expects clk and rst_n in the enclosing scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge once reset is released
`define TCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define TCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/tcs_pkg.sv =====
// package for the three-channel hysteresis squelch
// holds widths, register indexes, reset values and the config struct
package tcs_pkg;

  localparam int NUM_CH    = 3;
  localparam int SAMPLE_W  = 10;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_ENTER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_EXIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_ENTER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_EXIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_EN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 3'd5;

  localparam logic [BYTE_W-1:0] RST_LOW_ENTER  = 8'd10;
  localparam logic [BYTE_W-1:0] RST_LOW_EXIT   = 8'd20;
  localparam logic [BYTE_W-1:0] RST_HIGH_ENTER = 8'd245;
  localparam logic [BYTE_W-1:0] RST_HIGH_EXIT  = 8'd235;
  localparam logic              RST_HIGH_EN    = 1'b0;
  localparam logic [BYTE_W-1:0] RST_HOLD_TICKS = 8'd80;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [BYTE_W-1:0] BYTE_MAX   = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_ZERO  = 8'h00;
  localparam logic [BYTE_W-1:0] FRAME_MARK = 8'h01;

  typedef struct packed {
    logic [BYTE_W-1:0] low_enter;
    logic [BYTE_W-1:0] low_exit;
    logic [BYTE_W-1:0] high_enter;
    logic [BYTE_W-1:0] high_exit;
    logic              high_en;
    logic [BYTE_W-1:0] hold_ticks;
  } cfg_t;

endpackage

// ===== rtl/tcs_cfg_regs.sv =====
// configuration register file for the squelch
// depends on tcs_pkg
module tcs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [tcs_pkg::CFG_DAT_W-1:0]  wr_data,
  output tcs_pkg::cfg_t                  cfg
);

  tcs_pkg::cfg_t cfg_r;
  tcs_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        tcs_pkg::REG_LOW_ENTER:  cfg_nxt.low_enter  = wr_data;
        tcs_pkg::REG_LOW_EXIT:   cfg_nxt.low_exit   = wr_data;
        tcs_pkg::REG_HIGH_ENTER: cfg_nxt.high_enter = wr_data;
        tcs_pkg::REG_HIGH_EXIT:  cfg_nxt.high_exit  = wr_data;
        tcs_pkg::REG_HIGH_EN:    cfg_nxt.high_en    = wr_data[0];
        tcs_pkg::REG_HOLD_TICKS: cfg_nxt.hold_ticks = wr_data;
        default: ; // unused indexes are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_enter  <= tcs_pkg::RST_LOW_ENTER;
      cfg_r.low_exit   <= tcs_pkg::RST_LOW_EXIT;
      cfg_r.high_enter <= tcs_pkg::RST_HIGH_ENTER;
      cfg_r.high_exit  <= tcs_pkg::RST_HIGH_EXIT;
      cfg_r.high_en    <= tcs_pkg::RST_HIGH_EN;
      cfg_r.hold_ticks <= tcs_pkg::RST_HOLD_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/tcs_chan_gate.sv =====
// per-channel low/high hysteresis gate, purely combinational
// depends on tcs_pkg
module tcs_chan_gate (
  input  tcs_pkg::cfg_t                 cfg,
  input  logic [tcs_pkg::SAMPLE_W-1:0]  sample,
  input  logic                          low_flag,
  input  logic                          high_flag,
  output logic [tcs_pkg::BYTE_W-1:0]    gated,
  output logic                          low_flag_nxt,
  output logic                          high_flag_nxt
);

  logic [tcs_pkg::BYTE_W-1:0] raw;
  logic [tcs_pkg::BYTE_W-1:0] low_gated;

  assign raw = sample[tcs_pkg::SAMPLE_W-1 -: tcs_pkg::BYTE_W];

  always_comb begin
    low_flag_nxt = low_flag;
    low_gated    = raw;
    if (!low_flag) begin
      if (raw < cfg.low_enter) begin
        low_flag_nxt = 1'b1;
        low_gated    = tcs_pkg::BYTE_ZERO;
      end
    end else begin
      if (raw > cfg.low_exit) begin
        low_flag_nxt = 1'b0;
      end else begin
        low_gated = tcs_pkg::BYTE_ZERO;
      end
    end
  end

  // high gate sees the low gate's output; flags frozen while disabled
  always_comb begin
    high_flag_nxt = high_flag;
    gated         = low_gated;
    if (cfg.high_en) begin
      if (!high_flag) begin
        if (low_gated > cfg.high_enter) begin
          high_flag_nxt = 1'b1;
          gated         = tcs_pkg::BYTE_MAX;
        end
      end else begin
        if (low_gated < cfg.high_exit) begin
          high_flag_nxt = 1'b0;
        end else begin
          gated = tcs_pkg::BYTE_MAX;
        end
      end
    end
  end

endmodule

// ===== rtl/three_channel_hysteresis_squelch.sv =====
// top level of the three-channel hysteresis squelch
// depends on tcs_pkg, tcs_cfg_regs, tcs_chan_gate and assert_macros.svh
//
//   channel  direction  tdata / data                         tuser
//   in_      slave      [9:0] a, [19:10] b, [29:20] c        cmd
//   out_     master     [7:0] a, [15:8] b, [23:16] c         -
//   cfg_     slave      cfg_index 3 bits, cfg_data 8 bits    -
//
// one word accepted per cycle unless out_tready stalls; a frame's result word
// passes the input register, then the result register, and is made only while
// a channel is active or the hold count is non-zero; ticks give no word.
// the gate state and hold counter advance when a word leaves the input
// register, which it does whenever the result register is empty or taken.
// out_tready low holds the result; the input register still holds one word.
// synchronous active-low reset clears flags, counter and valids.
`include "assert_macros.svh"

module three_channel_hysteresis_squelch (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // sample_a, sample_b, sample_c, pad
  input  logic                          in_tuser,   // cmd
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [23:0]                   out_tdata,  // byte_a, byte_b, byte_c
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcs_pkg::CFG_DAT_W-1:0] cfg_data
);

  localparam int NCH = tcs_pkg::NUM_CH;
  localparam int SW  = tcs_pkg::SAMPLE_W;
  localparam int BW  = tcs_pkg::BYTE_W;

  tcs_pkg::cfg_t cfg;

  logic                 s1_valid_r;
  logic                 s1_cmd_r;
  logic [NCH-1:0][SW-1:0] s1_samp_r;
  logic                 adv;
  logic                 frame_adv;

  logic [NCH-1:0]         low_flags_r;
  logic [NCH-1:0]         high_flags_r;
  logic [NCH-1:0]         low_flags_nxt;
  logic [NCH-1:0]         high_flags_nxt;
  logic [NCH-1:0][BW-1:0] gated;
  logic [BW-1:0]          hold_count_r;
  logic [BW-1:0]          hold_count_nxt;
  logic                   any_active;
  logic                   send;

  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [NCH-1:0][BW-1:0] out_bytes_r;

  assign cfg_ready = 1'b1;

  tcs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // input register drains whenever the result register can take a word
  assign adv       = s1_valid_r & (~out_valid_r | out_tready);
  assign frame_adv = adv & (s1_cmd_r == tcs_pkg::CMD_FRAME);
  assign in_tready = ~s1_valid_r | adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready & in_tvalid) begin
      s1_cmd_r  <= in_tuser;
      s1_samp_r <= in_tdata[NCH*SW-1:0];
    end
  end

  for (genvar ch = 0; ch < NCH; ch++) begin : g_ch
    tcs_chan_gate u_gate (
      .cfg           (cfg),
      .sample        (s1_samp_r[ch]),
      .low_flag      (low_flags_r[ch]),
      .high_flag     (high_flags_r[ch]),
      .gated         (gated[ch]),
      .low_flag_nxt  (low_flags_nxt[ch]),
      .high_flag_nxt (high_flags_nxt[ch])
    );
  end

  assign any_active = ~(&low_flags_nxt);
  assign send       = any_active | (hold_count_r != '0);

  always_comb begin
    hold_count_nxt = hold_count_r;
    if (adv) begin
      if (s1_cmd_r == tcs_pkg::CMD_TICK) begin
        if (hold_count_r != '0) begin
          hold_count_nxt = hold_count_r - BW'(1);
        end
      end else if (any_active) begin
        hold_count_nxt = cfg.hold_ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_flags_r  <= '0;
      high_flags_r <= '0;
      hold_count_r <= '0;
    end else begin
      hold_count_r <= hold_count_nxt;
      if (frame_adv) begin
        low_flags_r  <= low_flags_nxt;
        high_flags_r <= high_flags_nxt;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_tready;
    if (frame_adv & send) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // frame marker on byte a, lsb cleared on b and c
  always_ff @(posedge clk) begin
    if (frame_adv & send) begin
      out_bytes_r[0] <= gated[0] | tcs_pkg::FRAME_MARK;
      for (int i = 1; i < NCH; i++) begin
        out_bytes_r[i] <= gated[i] & ~tcs_pkg::FRAME_MARK;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_bytes_r;

  `TCS_ASSERT(a_tick_no_word,
    (adv && s1_cmd_r == tcs_pkg::CMD_TICK && (!out_valid_r || out_tready)) |=> !out_valid_r,
    "tick produced an output word")
  `TCS_ASSERT(a_tick_countdown,
    (adv && s1_cmd_r == tcs_pkg::CMD_TICK) |=> (hold_count_r ==
      (($past(hold_count_r) == '0) ? '0 : BW'($past(hold_count_r) - BW'(1)))),
    "hold counter did not count down on tick")
  `TCS_ASSERT(a_active_sends,
    (frame_adv && any_active) |=> (out_valid_r && hold_count_r == $past(cfg.hold_ticks)),
    "active frame not sent or counter not reloaded")
  `TCS_ASSERT(a_marker_bits,
    out_valid_r |-> (out_bytes_r[0][0] && !out_bytes_r[1][0] && !out_bytes_r[2][0]),
    "frame marker bits wrong")

endmodule
